// ===== rtl/cda_pkg.sv =====
package cda_pkg;

    // width of the day count on the request
    localparam int ADD_WIDTH = 16;

    // the calendar repeats every 10000 years
    localparam int PERIOD_DAYS = 3652425;
    localparam int PERIOD_W    = 22;
    localparam int CNT_W       = (ADD_WIDTH > PERIOD_W) ? ADD_WIDTH : PERIOD_W;

    // year split into hundreds and units, y / 100 = (y * RECIP_100) >> RECIP_SHIFT
    localparam int RECIP_100   = 41944;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = 31;

    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [6:0]  YR_PART_MAX = 7'd99;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // held date, the year kept also as hundreds and units
    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [6:0]  yr_hi;
        logic [6:0]  yr_lo;
    } t_date;

    // gregorian leap rule from the two year parts
    function automatic logic leap_year(input logic [6:0] yr_hi, input logic [6:0] yr_lo);
        logic lo_zero;
        lo_zero = (yr_lo == 7'd0);
        return ((yr_lo[1:0] == 2'b00) && !lo_zero) || (lo_zero && (yr_hi[1:0] == 2'b00));
    endfunction

    // days in the month
    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/cda_day_step.sv =====
module cda_day_step (
    input  cda_pkg::t_date i_date,
    output cda_pkg::t_date o_date
);
    import cda_pkg::*;

    logic [4:0] len;
    logic [5:0] day_inc;
    logic       wrap_month;
    logic       wrap_year;
    logic       wrap_hi;

    // day increment against the month length
    assign len        = month_length(i_date.month, leap_year(i_date.yr_hi, i_date.yr_lo));
    assign day_inc    = {1'b0, i_date.day} + 6'd1;
    assign wrap_month = (day_inc > {1'b0, len});
    assign wrap_year  = wrap_month && (i_date.month >= MONTH_DEC);
    assign wrap_hi    = (i_date.yr_lo >= YR_PART_MAX);

    // next date
    always_comb begin
        o_date = i_date;
        if (wrap_month) begin
            o_date.day = 5'(day_inc - {1'b0, len});
        end else begin
            o_date.day = day_inc[4:0];
        end
        if (wrap_year) begin
            o_date.month = MONTH_JAN;
            if (i_date.year >= YEAR_MAX) begin
                o_date.year  = 14'd0;
                o_date.yr_hi = 7'd0;
                o_date.yr_lo = 7'd0;
            end else begin
                o_date.year = i_date.year + 14'd1;
                if (wrap_hi) begin
                    o_date.yr_lo = 7'd0;
                    o_date.yr_hi = i_date.yr_hi + 7'd1;
                end else begin
                    o_date.yr_lo = i_date.yr_lo + 7'd1;
                end
            end
        end else if (wrap_month) begin
            o_date.month = i_date.month + 4'd1;
        end
    end

endmodule

// ===== rtl/calendar_date_advance.sv =====
// from start to o_valid: load via S_SPLIT and S_LOW, advance by zero at once to S_REPORT,
//   advance by n days via S_REDUCE and S_STEP (one day stepped per cycle in the step unit)
// busy stays high until the strobe cycle ends, so a new request is taken only after the last result
// the result is shown for one cycle on o_valid, the receiver cannot stall
// synchronous active-low reset sets the date to 1 january of year 0
module calendar_date_advance (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [4:0]                     i_load_day,
    input  logic [3:0]                     i_load_month,
    input  logic [13:0]                    i_load_year,
    input  logic [cda_pkg::ADD_WIDTH-1:0]  i_days_to_add,
    output logic                           o_valid,
    output logic [4:0]                     o_cur_day,
    output logic [3:0]                     o_cur_month,
    output logic [13:0]                    o_cur_year,
    output logic                           o_leap_flag
);
    import cda_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SPLIT  = 6'b000010,
        S_LOW    = 6'b000100,
        S_REDUCE = 6'b001000,
        S_STEP   = 6'b010000,
        S_REPORT = 6'b100000
    } t_state;

    t_state           r_state, n_state;
    t_date            r_date,  n_date;
    logic [CNT_W-1:0] r_count, n_count;
    t_date            step_date;
    logic             accept;
    logic [PROD_W-1:0] split_prod;

    // shared one-day step unit
    cda_day_step u_step (
        .i_date (r_date),
        .o_date (step_date)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign split_prod = PROD_W'(r_date.year) * PROD_W'(RECIP_100);

    // sequencer
    always_comb begin
        n_state = r_state;
        n_date  = r_date;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_command) begin
                        // load with clamping of a zero day and an out-of-range month or year
                        n_date.day   = (i_load_day == 5'd0) ? 5'd1 : i_load_day;
                        n_date.month = (i_load_month == 4'd0) ? MONTH_JAN :
                                       (i_load_month > MONTH_DEC) ? MONTH_DEC : i_load_month;
                        n_date.year  = (i_load_year > YEAR_MAX) ? YEAR_MAX : i_load_year;
                        n_state      = S_SPLIT;
                    end else if (i_days_to_add == '0) begin
                        n_state = S_REPORT;
                    end else begin
                        // first day now, the rest reduced by the period
                        n_date  = step_date;
                        n_count = CNT_W'(i_days_to_add - ADD_WIDTH'(1));
                        n_state = S_REDUCE;
                    end
                end
            end
            S_SPLIT: begin
                n_date.yr_hi = split_prod[RECIP_SHIFT +: 7];
                n_state      = S_LOW;
            end
            S_LOW: begin
                n_date.yr_lo = 7'(r_date.year - 14'(r_date.yr_hi) * 14'd100);
                n_state      = S_REPORT;
            end
            S_REDUCE: begin
                if (r_count >= CNT_W'(PERIOD_DAYS)) begin
                    n_count = r_count - CNT_W'(PERIOD_DAYS);
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_count == '0) begin
                    n_state = S_REPORT;
                end else begin
                    n_date  = step_date;
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and date registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_date.day   <= 5'd1;
            r_date.month <= MONTH_JAN;
            r_date.year  <= 14'd0;
            r_date.yr_hi <= 7'd0;
            r_date.yr_lo <= 7'd0;
        end else begin
            r_state <= n_state;
            r_date  <= n_date;
        end
    end

    // remaining day count
    always_ff @(posedge i_clk) begin
        r_count <= n_count;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_REPORT);
    assign o_cur_day   = r_date.day;
    assign o_cur_month = r_date.month;
    assign o_cur_year  = r_date.year;
    assign o_leap_flag = leap_year(r_date.yr_hi, r_date.yr_lo);

    // checks
    a_report_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy after result strobe");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_count != '0) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("day count did not step down");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_month >= MONTH_JAN && o_cur_month <= MONTH_DEC && o_cur_day != 5'd0))
        else $error("reported date out of range");

    a_year_parts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (14'(r_date.yr_hi) * 14'd100 + 14'(r_date.yr_lo) == r_date.year))
        else $error("year parts disagree with year");

endmodule
